// ===== sv/nmm_pkg.sv =====
// Shared types and constants for the fixed-point Nelder-Mead minimizer.
// No dependencies; imported by nmm_blend, nmm_div and nelder_mead_minimizer.
`default_nettype none
package nmm_pkg;

	localparam int unsigned QW = 32;

	localparam logic OP_COORD = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_BEST = 1'b1;

	localparam logic [1:0] REG_DIMENSION  = 2'd0;
	localparam logic [1:0] REG_MAX_ITER   = 2'd1;
	localparam logic [1:0] REG_TOLERANCE  = 2'd2;
	localparam logic [1:0] REG_STEP_SIZE  = 2'd3;

	localparam logic [3:0]  DIMENSION_RST = 4'd2;
	localparam logic [15:0] MAX_ITER_RST  = 16'd1000;
	localparam logic [30:0] TOLERANCE_RST = 31'd66;
	localparam logic [31:0] STEP_SIZE_RST = 32'h0001_0000;

	typedef enum logic [1:0] {
		F_ONE,
		F_TWO,
		F_HALF
	} factor_t;

	// base + floor((a - b) * factor), saturated
	typedef struct packed {
		logic signed [QW-1:0] base;
		logic signed [QW-1:0] a;
		logic signed [QW-1:0] b;
		factor_t              factor;
	} blend_req_t;

endpackage
`default_nettype wire

// ===== sv/nmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nmm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 72
) (
	input  wire                         clk,
	input  wire                         we,
	input  wire  [$clog2(DEPTH)-1:0]    waddr,
	input  wire  [WIDTH-1:0]            wdata,
	input  wire  [$clog2(DEPTH)-1:0]    raddr,
	output logic [WIDTH-1:0]            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/nmm_blend.sv =====
// Shared arithmetic unit: base + floor((a - b) * factor), factor 1, 2 or 0.5,
// saturated to 32 bits. Depends on nmm_pkg.
`default_nettype none
module nmm_blend (
	input  nmm_pkg::blend_req_t    req,
	output logic signed [31:0]     res
);
	import nmm_pkg::*;

	logic signed [32:0] diff;
	logic signed [34:0] scaled;
	logic signed [34:0] sum;

	always_comb begin
		diff = 33'(req.a) - 33'(req.b);
		case (req.factor)
			F_TWO:   scaled = 35'(diff) <<< 1;
			F_HALF:  scaled = 35'(diff >>> 1);
			default: scaled = 35'(diff);
		endcase
		sum = 35'(req.base) + scaled;
		if (sum > 35'sd2147483647) begin
			res = 32'sh7FFF_FFFF;
		end else if (sum < -35'sd2147483648) begin
			res = 32'sh8000_0000;
		end else begin
			res = sum[31:0];
		end
	end
endmodule
`default_nettype wire

// ===== sv/nmm_div.sv =====
// Bit-serial signed-by-unsigned divider, floor rounding, for the centroid.
// One quotient bit per cycle. Depends on nmm_pkg.
`default_nettype none
module nmm_div #(
	parameter int unsigned SW  = 35,
	parameter int unsigned DVW = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  signed [SW-1:0]    dividend,
	input  wire         [DVW-1:0]   divisor,
	output logic                    done,
	output logic signed [31:0]      quotient
);
	import nmm_pkg::*;

	localparam int unsigned CNTW = $clog2(SW + 1);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIX
	} dstate_t;

	dstate_t          state_q;
	logic [SW-1:0]    a_q;
	logic [DVW-1:0]   rem_q;
	logic [DVW-1:0]   div_q;
	logic [CNTW-1:0]  cnt_q;
	logic             neg_q;
	logic [DVW:0]     rem_nx;
	logic             fit;
	logic [SW-1:0]    qfix;

	always_comb begin
		rem_nx = {rem_q, a_q[SW-1]};
		fit    = rem_nx >= {1'b0, div_q};
		qfix   = neg_q ? (SW'(0) - a_q - SW'(rem_q != '0)) : a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= dividend[SW-1];
						a_q     <= dividend[SW-1] ? (SW'(0) - dividend) : dividend;
						div_q   <= divisor;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fit ? DVW'(rem_nx - {1'b0, div_q}) : rem_nx[DVW-1:0];
					a_q   <= {a_q[SW-2:0], fit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(SW - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					quotient <= qfix[31:0];
					done     <= 1'b1;
					state_q  <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/nelder_mead_minimizer.sv =====
// Top level: sequencer, simplex store and value registers of the minimizer.
// Depends on nmm_pkg, nmm_ram, nmm_blend, nmm_div.
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser operation, tdata coordinate|value
// m_axis    out  m_axis_tvalid/tready      tuser kind, tlast, tdata see port
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// Every step reuses one simplex RAM read port and one blend unit; the centroid
// divider is bit-serial over the SW = 32 + log2 MAX_DIM bits of its dividend.
// Input is taken only while waiting for a coordinate or a value; the output
// register holds a word while the next one is prepared. Reset clears control
// state only, with no clearing pass.
`default_nettype none
module nelder_mead_minimizer #(
	parameter int unsigned MAX_DIM = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // [31:0] guess_coordinate, [63:32] objective_value
	input  wire         s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [87:0] m_axis_tdata,   // [31:0] coordinate, [63:32] best_value,
	                                    // [79:64] iterations_done, [80] converged
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast,   // last_coordinate
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import nmm_pkg::*;

	localparam int unsigned NV = MAX_DIM + 1;
	localparam int unsigned VW = $clog2(NV);
	localparam int unsigned DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned RD = NV * MAX_DIM;
	localparam int unsigned AW = $clog2(RD);
	localparam int unsigned SW = 32 + $clog2(MAX_DIM);

	typedef enum logic [4:0] {
		ST_IN, ST_BUILD_RD, ST_BUILD_LD, ST_BUILD_WR, ST_WAIT, ST_ITER,
		ST_SORT_LD, ST_SORT_CMP, ST_SORT_DONE, ST_CEN_RD, ST_CEN_ACC,
		ST_CEN_RDW, ST_CEN_DIV, ST_CEN_WAITDIV, ST_TRIAL_RD, ST_TRIAL_WR,
		ST_REPL, ST_SHR_START, ST_SHR_RDB, ST_SHR_RDX, ST_SHR_WR,
		ST_EM_RD, ST_EM_WR
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_INIT, PH_REFL, PH_EXPAND, PH_COUT, PH_CIN, PH_SHRINK
	} phase_t;

	typedef enum logic [1:0] {
		SRC_RAM, SRC_REFL, SRC_TRIAL
	} src_t;

	state_t state_q;
	phase_t phase_q;

	logic [3:0]  dim_q;
	logic [15:0] maxit_q;
	logic [30:0] tol_q;
	logic [31:0] step_q;

	logic [VW-1:0] n_q, ccount_q, vcount_q, d_q, k_q, si_q, cnt_q;
	logic [VW-1:0] b_q, w_q, sidx_q, em_v_q;
	logic [15:0]   iter_q;
	logic          fin_q, from_ram_q, rep_trial_q, em_kind_q, em_conv_q;
	factor_t       tfac_q;
	src_t          em_src_q;

	logic signed [31:0] pv_q    [NV];
	logic        [VW-1:0] rank_q [NV];
	logic signed [31:0] cen_q   [MAX_DIM];
	logic signed [31:0] refl_q  [MAX_DIM];
	logic signed [31:0] trial_q [MAX_DIM];
	logic signed [31:0] rv_q, vi_q, bestv_q, worstv_q, swv_q, wc_q, bb_q, p0_q;
	logic signed [SW-1:0] sum_q;

	logic        out_valid_q, out_kind_q, out_last_q, out_conv_q;
	logic [31:0] out_coord_q, out_best_q;
	logic [15:0] out_iter_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [31:0]       ram_wdata, ram_rdata;
	blend_req_t        breq;
	logic signed [31:0] bres;
	logic              div_done;
	logic signed [31:0] div_q;

	logic              s_acc, out_free, op, sort_less, d_last, tol_hit;
	logic signed [31:0] g_in, v_in, pv_rd, em_coord, from_c;
	logic [VW-1:0]     pv_idx, rank_idx, rank_rd, cntn, n_dec, dim_cl;
	logic [VW:0]       vc1;
	logic [DW-1:0]     dd;

	function automatic logic [AW-1:0] vaddr(input logic [VW-1:0] v, input logic [VW-1:0] d);
		return AW'(v) * AW'(MAX_DIM) + AW'(d);
	endfunction

	nmm_ram #(.WIDTH(32), .DEPTH(RD)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nmm_blend u_blend (
		.req (breq),
		.res (bres)
	);

	nmm_div #(.SW(SW), .DVW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_CEN_DIV),
		.dividend (sum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		s_acc    = s_axis_tvalid & s_axis_tready;
		out_free = !out_valid_q || m_axis_tready;
		op       = s_axis_tuser;
		g_in     = s_axis_tdata[31:0];
		v_in     = s_axis_tdata[63:32];
		dd       = d_q[DW-1:0];
		n_dec    = n_q - 1'b1;
		d_last   = d_q == n_dec;
		vc1      = {1'b0, vcount_q} + 1'b1;
		if (dim_q == 4'd0) begin
			dim_cl = VW'(1);
		end else if (32'(dim_q) > MAX_DIM) begin
			dim_cl = VW'(MAX_DIM);
		end else begin
			dim_cl = VW'(dim_q);
		end
		pv_idx   = (state_q == ST_SORT_LD) ? si_q : k_q;
		pv_rd    = pv_q[pv_idx];
		sort_less = (pv_rd < vi_q) || ((pv_rd == vi_q) && (k_q < si_q));
		cntn     = cnt_q + VW'(sort_less);
		rank_idx = (state_q == ST_SHR_START) ? vcount_q : k_q;
		rank_rd  = rank_q[rank_idx];
		tol_hit  = ($signed({worstv_q[31], worstv_q}) - $signed({bestv_q[31], bestv_q}))
		           < $signed({2'b00, tol_q});
		from_c   = from_ram_q ? ram_rdata : refl_q[dd];
		case (em_src_q)
			SRC_REFL:  em_coord = refl_q[dd];
			SRC_TRIAL: em_coord = trial_q[dd];
			default:   em_coord = ram_rdata;
		endcase

		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		breq      = '{base: p0_q, a: step_q, b: '0, factor: F_ONE};
		case (state_q)
			ST_IN: begin
				ram_we    = s_acc && (op == OP_COORD);
				ram_waddr = vaddr('0, ccount_q);
				ram_wdata = g_in;
			end
			ST_BUILD_RD: ram_raddr = vaddr('0, d_q);
			ST_BUILD_WR: begin
				ram_we    = 1'b1;
				ram_waddr = vaddr(k_q, d_q);
				ram_wdata = ((k_q - 1'b1) == d_q) ? bres : p0_q;
			end
			ST_CEN_RD:  ram_raddr = vaddr(rank_rd, d_q);
			ST_CEN_RDW: ram_raddr = vaddr(w_q, d_q);
			ST_CEN_WAITDIV: breq = '{base: div_q, a: div_q, b: wc_q, factor: F_ONE};
			ST_TRIAL_RD: ram_raddr = vaddr(w_q, d_q);
			ST_TRIAL_WR: breq = '{base: cen_q[dd], a: from_c, b: cen_q[dd], factor: tfac_q};
			ST_REPL: begin
				ram_we    = 1'b1;
				ram_waddr = vaddr(w_q, d_q);
				ram_wdata = rep_trial_q ? trial_q[dd] : refl_q[dd];
			end
			ST_SHR_RDB: ram_raddr = vaddr(b_q, d_q);
			ST_SHR_RDX: ram_raddr = vaddr(sidx_q, d_q);
			ST_SHR_WR: begin
				breq      = '{base: bb_q, a: ram_rdata, b: bb_q, factor: F_HALF};
				ram_we    = 1'b1;
				ram_waddr = vaddr(sidx_q, d_q);
				ram_wdata = bres;
			end
			// keep the read address while the output register is busy
			ST_EM_RD, ST_EM_WR: ram_raddr = vaddr(em_v_q, d_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			phase_q     <= PH_IDLE;
			dim_q       <= DIMENSION_RST;
			maxit_q     <= MAX_ITER_RST;
			tol_q       <= TOLERANCE_RST;
			step_q      <= STEP_SIZE_RST;
			n_q         <= VW'(1);
			ccount_q    <= '0;
			vcount_q    <= '0;
			iter_q      <= '0;
			d_q         <= '0;
			k_q         <= '0;
			si_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NV; i++) begin
				rank_q[i] <= VW'(i);
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_DIMENSION: dim_q   <= cfg_data[3:0];
					REG_MAX_ITER:  maxit_q <= cfg_data[15:0];
					REG_TOLERANCE: tol_q   <= cfg_data[30:0];
					REG_STEP_SIZE: step_q  <= cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_EM_WR)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IN: begin
					if (s_acc && op == OP_COORD) begin
						if (ccount_q == '0) begin
							n_q <= dim_cl;
						end
						ccount_q <= ccount_q + 1'b1;
						if ((ccount_q + 1'b1) >= ((ccount_q == '0) ? dim_cl : n_q)) begin
							d_q     <= '0;
							state_q <= ST_BUILD_RD;
						end
					end
				end
				ST_BUILD_RD: state_q <= ST_BUILD_LD;
				ST_BUILD_LD: begin
					p0_q    <= ram_rdata;
					k_q     <= VW'(1);
					state_q <= ST_BUILD_WR;
				end
				ST_BUILD_WR: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q) begin
						if (d_last) begin
							iter_q    <= '0;
							vcount_q  <= '0;
							phase_q   <= PH_INIT;
							em_src_q  <= SRC_RAM;
							em_v_q    <= '0;
							em_kind_q <= KIND_EVAL;
							em_conv_q <= 1'b0;
							d_q       <= '0;
							state_q   <= ST_EM_RD;
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= ST_BUILD_RD;
						end
					end
				end
				ST_WAIT: begin
					if (s_acc && op == OP_VALUE) begin
						d_q <= '0;
						case (phase_q)
							PH_INIT: begin
								pv_q[vcount_q] <= v_in;
								vcount_q       <= vc1[VW-1:0];
								if (vc1 <= {1'b0, n_q}) begin
									em_src_q  <= SRC_RAM;
									em_v_q    <= vc1[VW-1:0];
									em_kind_q <= KIND_EVAL;
									em_conv_q <= 1'b0;
									state_q   <= ST_EM_RD;
								end else begin
									state_q <= ST_ITER;
								end
							end
							PH_REFL: begin
								rv_q <= v_in;
								if (v_in < bestv_q) begin
									from_ram_q <= 1'b0;
									tfac_q     <= F_TWO;
									phase_q    <= PH_EXPAND;
									state_q    <= ST_TRIAL_RD;
								end else if (v_in < swv_q) begin
									pv_q[w_q]   <= v_in;
									rep_trial_q <= 1'b0;
									state_q     <= ST_REPL;
								end else if (v_in < worstv_q) begin
									from_ram_q <= 1'b0;
									tfac_q     <= F_HALF;
									phase_q    <= PH_COUT;
									state_q    <= ST_TRIAL_RD;
								end else begin
									from_ram_q <= 1'b1;
									tfac_q     <= F_HALF;
									phase_q    <= PH_CIN;
									state_q    <= ST_TRIAL_RD;
								end
							end
							PH_EXPAND: begin
								pv_q[w_q]   <= (v_in < rv_q) ? v_in : rv_q;
								rep_trial_q <= v_in < rv_q;
								state_q     <= ST_REPL;
							end
							PH_COUT, PH_CIN: begin
								if ((phase_q == PH_COUT) ? (v_in <= rv_q) : (v_in < worstv_q)) begin
									pv_q[w_q]   <= v_in;
									rep_trial_q <= 1'b1;
									state_q     <= ST_REPL;
								end else begin
									vcount_q <= VW'(1);
									state_q  <= ST_SHR_START;
								end
							end
							PH_SHRINK: begin
								pv_q[sidx_q] <= v_in;
								if (vc1 > {1'b0, n_q}) begin
									iter_q  <= iter_q + 1'b1;
									state_q <= ST_ITER;
								end else begin
									vcount_q <= vc1[VW-1:0];
									state_q  <= ST_SHR_START;
								end
							end
							default: begin
								phase_q  <= PH_IDLE;
								ccount_q <= '0;
								state_q  <= ST_IN;
							end
						endcase
					end
				end
				ST_ITER: begin
					fin_q   <= iter_q >= maxit_q;
					si_q    <= '0;
					state_q <= ST_SORT_LD;
				end
				ST_SORT_LD: begin
					vi_q    <= pv_rd;
					k_q     <= '0;
					cnt_q   <= '0;
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (k_q == n_q) begin
						rank_q[cntn] <= si_q;
						if (cntn == '0) begin
							b_q     <= si_q;
							bestv_q <= vi_q;
						end
						if (cntn == n_q) begin
							w_q      <= si_q;
							worstv_q <= vi_q;
						end
						if (cntn == n_dec) begin
							swv_q <= vi_q;
						end
						si_q    <= si_q + 1'b1;
						state_q <= (si_q == n_q) ? ST_SORT_DONE : ST_SORT_LD;
					end else begin
						k_q   <= k_q + 1'b1;
						cnt_q <= cntn;
					end
				end
				ST_SORT_DONE: begin
					d_q <= '0;
					if (fin_q || tol_hit) begin
						phase_q   <= PH_IDLE;
						ccount_q  <= '0;
						em_src_q  <= SRC_RAM;
						em_v_q    <= b_q;
						em_kind_q <= KIND_BEST;
						em_conv_q <= !fin_q;
						state_q   <= ST_EM_RD;
					end else begin
						k_q     <= '0;
						sum_q   <= '0;
						state_q <= ST_CEN_RD;
					end
				end
				ST_CEN_RD: state_q <= ST_CEN_ACC;
				ST_CEN_ACC: begin
					sum_q <= sum_q + SW'(signed'(ram_rdata));
					if (k_q == n_dec) begin
						state_q <= ST_CEN_RDW;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_CEN_RD;
					end
				end
				ST_CEN_RDW: state_q <= ST_CEN_DIV;
				ST_CEN_DIV: begin
					wc_q    <= ram_rdata;
					state_q <= ST_CEN_WAITDIV;
				end
				ST_CEN_WAITDIV: begin
					if (div_done) begin
						cen_q[dd]  <= div_q;
						refl_q[dd] <= bres;
						if (d_last) begin
							phase_q   <= PH_REFL;
							em_src_q  <= SRC_REFL;
							em_kind_q <= KIND_EVAL;
							em_conv_q <= 1'b0;
							d_q       <= '0;
							state_q   <= ST_EM_RD;
						end else begin
							d_q     <= d_q + 1'b1;
							k_q     <= '0;
							sum_q   <= '0;
							state_q <= ST_CEN_RD;
						end
					end
				end
				ST_TRIAL_RD: state_q <= ST_TRIAL_WR;
				ST_TRIAL_WR: begin
					trial_q[dd] <= bres;
					if (d_last) begin
						em_src_q  <= SRC_TRIAL;
						em_kind_q <= KIND_EVAL;
						em_conv_q <= 1'b0;
						d_q       <= '0;
						state_q   <= ST_EM_RD;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= ST_TRIAL_RD;
					end
				end
				ST_REPL: begin
					if (d_last) begin
						iter_q  <= iter_q + 1'b1;
						state_q <= ST_ITER;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				ST_SHR_START: begin
					sidx_q  <= rank_rd;
					d_q     <= '0;
					state_q <= ST_SHR_RDB;
				end
				ST_SHR_RDB: state_q <= ST_SHR_RDX;
				ST_SHR_RDX: begin
					bb_q    <= ram_rdata;
					state_q <= ST_SHR_WR;
				end
				ST_SHR_WR: begin
					if (d_last) begin
						phase_q   <= PH_SHRINK;
						em_src_q  <= SRC_RAM;
						em_v_q    <= sidx_q;
						em_kind_q <= KIND_EVAL;
						em_conv_q <= 1'b0;
						d_q       <= '0;
						state_q   <= ST_EM_RD;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= ST_SHR_RDB;
					end
				end
				ST_EM_RD: state_q <= ST_EM_WR;
				ST_EM_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= em_kind_q;
						out_coord_q <= em_coord;
						out_last_q  <= d_last;
						out_best_q  <= (em_kind_q == KIND_BEST) ? bestv_q : '0;
						out_iter_q  <= (em_kind_q == KIND_BEST) ? iter_q : '0;
						out_conv_q  <= (em_kind_q == KIND_BEST) && em_conv_q;
						if (d_last) begin
							state_q <= (em_kind_q == KIND_BEST) ? ST_IN : ST_WAIT;
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= ST_EM_RD;
						end
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IN) || (state_q == ST_WAIT);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_conv_q, out_iter_q, out_best_q, out_coord_q};

endmodule
`default_nettype wire
